/* hw/rtl/meter_request_frame_encoder_top_assert.svh */
// Assertion macros for the meter request frame encoder checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef METER_REQUEST_FRAME_ENCODER_TOP_ASSERT_SVH
`define METER_REQUEST_FRAME_ENCODER_TOP_ASSERT_SVH

// Consequent in the same cycle, checked out of reset only
`define MRFE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame encoder check failed");

// Consequent in the cycle after the antecedent, checked out of reset only
`define MRFE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame encoder check failed");

// Consequent in the cycle after the antecedent, checked during reset as well
`define MRFE_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("frame encoder reset check failed");

`endif

/* hw/rtl/mrfe_pkg.sv */
// Shared types, constants and helper functions of the meter request frame encoder.
// No dependencies.
package mrfe_pkg;

    localparam logic [7:0] FRAME_MARK = 8'hC0;
    localparam logic [7:0] FRAME_HEAD = 8'h48;
    localparam logic [7:0] FILL_BYTE  = 8'hFF;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] SUM_BODY   = 8'h01;
    localparam logic [7:0] CRC_POLY   = 8'hB5;

    localparam logic [7:0] KIND_CODE_PLAIN  = 8'hD0;
    localparam logic [7:0] KIND_CODE_SUM    = 8'hD1;
    localparam logic [7:0] KIND_CODE_TARIFF = 8'hD2;
    localparam logic [7:0] KIND_CODE_HOURLY = 8'hD5;

    typedef enum logic [1:0] {
        KIND_PLAIN  = 2'd0,
        KIND_SUM    = 2'd1,
        KIND_TARIFF = 2'd2,
        KIND_HOURLY = 2'd3
    } t_kind;

    // Frame byte positions
    localparam logic [4:0] POS_HEAD    = 5'd1;
    localparam logic [4:0] POS_ADDR_LO = 5'd2;
    localparam logic [4:0] POS_ADDR_HI = 5'd3;
    localparam logic [4:0] POS_FILL    = 5'd4;
    localparam logic [4:0] POS_KIND    = 5'd10;
    localparam logic [4:0] POS_CMD_HI  = 5'd11;
    localparam logic [4:0] POS_CMD_LO  = 5'd12;
    localparam logic [4:0] POS_BODY    = 5'd13;

    localparam int BODY_MAX = 5;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic REG_METER_ADDRESS = 1'b0;

    typedef struct packed {
        logic [7:0]                 kind_code;
        logic [15:0]                cmd;
        logic [2:0]                 body_len;
        logic [BODY_MAX-1:0][7:0]   body;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic {
        BK_IDLE,
        BK_SEND
    } t_back_state;

    // CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

    // Tens nibble and units nibble; tens come from v * 205 >> 11, exact below 1029
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 15'(v) * 15'd205;
        tens  = prod[14:11];
        units = v - 7'(7'(tens) * 7'd10);
        return {tens, units[3:0]};
    endfunction

endpackage

/* hw/rtl/mrfe_queue.sv */
// Short descriptor queue between the front and back parts of the frame encoder.
// Depends on mrfe_pkg.
module mrfe_queue
    import mrfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_req    i_req,
    input  logic    i_pop,
    output t_req    o_head,
    output t_q_stat o_stat
);

    t_req              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

/* hw/rtl/mrfe_front.sv */
// Front part of the frame encoder: accepts request items and turns them into descriptors.
// Depends on mrfe_pkg.
module mrfe_front
    import mrfe_pkg::*;
(
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_command_code,
    input  logic [1:0]  i_frame_kind,
    input  logic [7:0]  i_param_byte,
    input  logic [7:0]  i_index_byte,
    input  logic [4:0]  i_day_of_month,
    input  logic [3:0]  i_month_number,
    input  logic [6:0]  i_year_in_century,
    input  logic [4:0]  i_hour_of_day,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_req        o_req
);

    t_kind kind;

    assign kind    = t_kind'(i_frame_kind);
    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    always_comb begin
        o_req          = '0;
        o_req.cmd      = i_command_code;
        case (kind)
            KIND_PLAIN: begin
                o_req.kind_code = KIND_CODE_PLAIN;
                o_req.body_len  = 3'd0;
            end
            KIND_SUM: begin
                o_req.kind_code = KIND_CODE_SUM;
                o_req.body_len  = 3'd1;
                o_req.body[0]   = SUM_BODY;
            end
            KIND_TARIFF: begin
                o_req.kind_code = KIND_CODE_TARIFF;
                o_req.body_len  = 3'd2;
                o_req.body[0]   = i_param_byte;
                o_req.body[1]   = i_index_byte;
            end
            KIND_HOURLY: begin
                o_req.kind_code = KIND_CODE_HOURLY;
                o_req.body_len  = 3'd5;
                o_req.body[0]   = to_bcd(7'(i_day_of_month));
                o_req.body[1]   = to_bcd(7'(i_month_number));
                o_req.body[2]   = to_bcd(i_year_in_century);
                o_req.body[3]   = 8'(i_hour_of_day);
                o_req.body[4]   = i_param_byte;
            end
            default: begin
                o_req.kind_code = KIND_CODE_PLAIN;
            end
        endcase
    end

endmodule

/* hw/rtl/mrfe_back.sv */
// Back part of the frame encoder: walks one descriptor byte by byte, running the CRC.
// Depends on mrfe_pkg.
module mrfe_back
    import mrfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_meter_address,
    input  t_req        i_head,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end
);

    t_back_state r_state, n_state;
    t_req        r_desc;
    logic [4:0]  r_idx;
    logic [7:0]  r_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_end;

    logic        advance;
    logic        at_last;
    logic        in_crc;
    logic        sending;
    logic [4:0]  body_rel;
    logic [7:0]  cur_byte;

    assign advance  = !r_out_valid || !i_stall;
    assign at_last  = (r_idx == 5'd14 + 5'(r_desc.body_len));
    assign in_crc   = (r_idx != '0) && (r_idx < POS_BODY + 5'(r_desc.body_len));
    assign body_rel = r_idx - POS_BODY;

    always_comb begin
        if (r_idx == '0 || at_last) begin
            cur_byte = FRAME_MARK;
        end else if (r_idx == POS_BODY + 5'(r_desc.body_len)) begin
            cur_byte = r_crc;
        end else if (r_idx >= POS_BODY) begin
            cur_byte = r_desc.body[body_rel[2:0]];
        end else begin
            case (r_idx)
                POS_HEAD:    cur_byte = FRAME_HEAD;
                POS_ADDR_LO: cur_byte = i_meter_address[7:0];
                POS_ADDR_HI: cur_byte = i_meter_address[15:8];
                POS_FILL:    cur_byte = FILL_BYTE;
                POS_KIND:    cur_byte = r_desc.kind_code;
                POS_CMD_HI:  cur_byte = r_desc.cmd[15:8];
                POS_CMD_LO:  cur_byte = r_desc.cmd[7:0];
                default:     cur_byte = ZERO_BYTE;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = BK_SEND;
                end
            end
            BK_SEND: begin
                if (advance && at_last && i_q_stat.empty) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        sending = 1'b0;
        o_pop   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop = !i_q_stat.empty;
            end
            BK_SEND: begin
                sending = advance;
                o_pop   = advance && at_last && !i_q_stat.empty;
            end
            default: begin
                sending = 1'b0;
                o_pop   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_idx       <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_idx <= '0;
                r_crc <= '0;
            end else if (sending) begin
                r_idx <= r_idx + 1'b1;
                if (in_crc) begin
                    r_crc <= crc8_next(r_crc, cur_byte);
                end
            end
            if (advance) begin
                r_out_valid <= (r_state == BK_SEND);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_head;
        end
        if (sending) begin
            r_out_byte <= cur_byte;
            r_out_end  <= at_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_end  = r_out_end;

endmodule

/* hw/rtl/meter_request_frame_encoder_top.sv */
// Meter request frame encoder: every accepted request becomes one byte-serial frame
// (C0 48 address FF 00x5 kind command body CRC-8 C0). An item is accepted whenever the
// two-entry descriptor queue has room, so items can arrive in consecutive cycles; the
// back end then sends one byte per cycle through its output register while i_stall is
// low, in frames of 15, 16, 17 or 20 bytes for kinds plain, sum, tariff and hourly, and
// follows a closing C0 directly with the next queued frame. The byte sequencer sets
// the sustained rate. The meter address is in a 32-bit APB register at byte address 0.
// Depends on mrfe_pkg, mrfe_front, mrfe_queue and mrfe_back.
module meter_request_frame_encoder_top
    import mrfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_command_code,
    input  logic [1:0]  i_frame_kind,
    input  logic [7:0]  i_param_byte,
    input  logic [7:0]  i_index_byte,
    input  logic [4:0]  i_day_of_month,
    input  logic [3:0]  i_month_number,
    input  logic [6:0]  i_year_in_century,
    input  logic [4:0]  i_hour_of_day,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end
);

    logic [15:0] r_meter_address;
    logic        cfg_wr;
    logic        push;
    logic        pop;
    t_req        front_req;
    t_req        q_head;
    t_q_stat     q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meter_address <= '0;
        end else if (cfg_wr && paddr[2] == REG_METER_ADDRESS) begin
            r_meter_address <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_METER_ADDRESS) ? 32'(r_meter_address) : '0;

    mrfe_front u_front (
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command_code    (i_command_code),
        .i_frame_kind      (i_frame_kind),
        .i_param_byte      (i_param_byte),
        .i_index_byte      (i_index_byte),
        .i_day_of_month    (i_day_of_month),
        .i_month_number    (i_month_number),
        .i_year_in_century (i_year_in_century),
        .i_hour_of_day     (i_hour_of_day),
        .i_q_stat          (q_stat),
        .o_push            (push),
        .o_req             (front_req)
    );

    mrfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    mrfe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_meter_address (r_meter_address),
        .i_head          (q_head),
        .i_q_stat        (q_stat),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_frame_byte    (o_frame_byte),
        .o_frame_end     (o_frame_end)
    );

endmodule

/* hw/rtl/mrfe_checker.sv */
// Port-level checks on the frame output of the meter request frame encoder.
// Depends on meter_request_frame_encoder_top_assert.svh; bound to the top level.
`include "meter_request_frame_encoder_top_assert.svh"

module mrfe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_frame_byte,
    input logic       o_frame_end
);

    // Hold a stalled byte
    `MRFE_ASSERT_NEXT(a_stall_hold, o_valid && i_stall, o_valid && $stable(o_frame_byte) && $stable(o_frame_end))

    // Frame closes on the marker byte
    `MRFE_ASSERT_NOW(a_end_is_mark, o_valid && o_frame_end, o_frame_byte == 8'hC0)

    // After a closing transfer the next byte shown opens a frame
    `MRFE_ASSERT_NEXT(a_open_after_end, o_valid && !i_stall && o_frame_end, !o_valid || o_frame_byte == 8'hC0)

    // Drop output during reset
    `MRFE_ASSERT_NEXT_ALWAYS(a_reset_idle, !i_rst_n, !o_valid)

endmodule

bind meter_request_frame_encoder_top mrfe_checker u_mrfe_checker (.*);
